>>> rtl/fatm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm timer package
// Action codes, field widths and the command struct passed to the alarm bank.
// ----------------------------------------------------------------------------
package fatm_pkg;

   localparam int unsigned ACTION_W   = 4;
   localparam int unsigned UNIT_W     = 2;
   localparam int unsigned CHAN_W     = 3;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned MASK_W     = 4;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 40;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK    = 4'd0,
      ACT_INIT    = 4'd1,
      ACT_SET_REL = 4'd2,
      ACT_SET_ABS = 4'd3,
      ACT_SET_PER = 4'd4,
      ACT_CLEAR   = 4'd5,
      ACT_READ    = 4'd6,
      ACT_START   = 4'd7,
      ACT_STOP    = 4'd8
   } action_type;

   typedef enum logic {
      CSR_RESET_ON_MATCH = 1'b0,
      CSR_RESET_ON_SET   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               tick;
      logic [VALUE_W-1:0] now;
      logic               reset_on_match;
      logic               init;
      logic               set;
      logic               clear;
      logic [CHAN_W-1:0]  channel;
      logic [VALUE_W-1:0] set_time;
      logic [VALUE_W-1:0] set_period;
   } bank_cmd_type;

endpackage

>>> rtl/four_channel_alarm_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-channel alarm timer core
// 64-bit tick counter, stepped by running ticks, with compare alarm channels.
//
// Each request word carries one action: tick, init, set relative, set
// absolute, set periodic, clear, read, start or stop. Every request word
// produces exactly one response word with the fired mask, the read value
// and an index error status.
// The action is carried out in the cycle the request word is accepted: the
// counter, run flag and alarm registers update at that edge and the response
// is loaded into the output register, which presents it in the next cycle.
// Throughput is one word per cycle while the response receiver keeps up.
// When the response receiver stalls, the output register holds its word and
// one new request is still accepted in the cycle the held word is taken.
// Reset leaves the counter at zero, paused, with all channels disarmed and
// both control registers cleared. The control registers are to be written
// through the csr port only while no request is in flight; that is the
// user's duty, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module four_channel_alarm_timer_core
   import fatm_pkg::*;
#(
   parameter int unsigned CHANNELS = 4,
   parameter int unsigned UNITS    = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: action[3:0], unit[5:4], channel[8:6], value[40:9].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: fired_mask[3:0], read_value[35:4], status[36].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic                  csr_wdata
);

   logic [63:0]           count_ff;
   logic [63:0]           count_in;
   logic [63:0]           count_inc;
   logic [63:0]           count_step;
   logic                  match_clear;
   logic                  running_ff;
   logic                  running_in;
   logic                  rom_ff;
   logic                  ros_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic                  accept;
   action_type            action;
   logic [UNIT_W-1:0]     unit;
   logic [CHAN_W-1:0]     channel;
   logic [VALUE_W-1:0]    value;
   logic                  unit_ok;
   logic                  chan_ok;
   logic                  err;
   logic [VALUE_W-1:0]    low;
   logic [VALUE_W-1:0]    set_base;
   logic [MASK_W-1:0]     fired_mask;
   logic [VALUE_W-1:0]    read_value;
   logic [CHANNELS-1:0]   fired;
   bank_cmd_type          cmd;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign action  = action_type'(req_tdata[3:0]);
   assign unit    = req_tdata[5:4];
   assign channel = req_tdata[8:6];
   assign value   = req_tdata[40:9];

   assign unit_ok   = {1'b0, unit} < 3'(UNITS);
   assign chan_ok   = {1'b0, channel} < 4'(CHANNELS);
   assign low       = count_ff[VALUE_W-1:0];
   assign count_inc = count_ff + 64'd1;
   assign set_base  = ((action == ACT_SET_PER) && ros_ff) ? '0 : low;

   always_comb begin
      cmd            = '0;
      cmd.now        = count_inc[VALUE_W-1:0];
      cmd.reset_on_match = rom_ff;
      cmd.channel    = channel;
      cmd.set_time   = (action == ACT_SET_ABS) ? value : set_base + value;
      cmd.set_period = (action == ACT_SET_PER) ? value : '0;
      count_step     = count_ff;
      running_in     = running_ff;
      err            = 1'b0;
      read_value     = '0;

      unique case (action)
         ACT_TICK: begin
            if (accept && running_ff) begin
               cmd.tick   = 1'b1;
               count_step = count_inc;
            end
         end
         ACT_INIT: begin
            err = !unit_ok;
            if (accept && !err) begin
               cmd.init   = 1'b1;
               count_step = '0;
               running_in = 1'b1;
            end
         end
         ACT_SET_REL, ACT_SET_ABS, ACT_SET_PER: begin
            err = !unit_ok || !chan_ok;
            if (accept && !err) begin
               cmd.set = 1'b1;
               if (action == ACT_SET_ABS || (action == ACT_SET_PER && ros_ff)) begin
                  count_step = '0;
               end
               if (action != ACT_SET_REL) begin
                  running_in = 1'b1;
               end
            end
         end
         ACT_CLEAR: begin
            err = !unit_ok || !chan_ok;
            cmd.clear = accept && !err;
         end
         ACT_READ: begin
            err = !unit_ok;
            if (!err) begin
               read_value = low;
            end
         end
         ACT_START: begin
            err = !unit_ok;
            if (accept && !err) begin
               running_in = 1'b1;
            end
         end
         ACT_STOP: begin
            err = !unit_ok;
            if (accept && !err) begin
               running_in = 1'b0;
            end
         end
         default: begin
            err = 1'b0;
         end
      endcase
   end

   assign match_clear = (|fired) && rom_ff;
   assign count_in    = match_clear ? '0 : count_step;
   assign fired_mask  = MASK_W'(fired);
   assign rsp_data_in = {3'b000, err, read_value, fired_mask};

   fatm_alarm_bank #(
      .CHANNELS (CHANNELS)
   ) u_bank (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .fired (fired)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         running_ff   <= 1'b0;
         rom_ff       <= 1'b0;
         ros_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         running_ff <= running_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_RESET_ON_MATCH: rom_ff <= csr_wdata;
               CSR_RESET_ON_SET:   ros_ff <= csr_wdata;
            endcase
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A paused tick leaves the counter untouched.
   assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_TICK && !running_ff |=> count_ff == $past(count_ff))
      else $error("paused tick changed the counter");

   // A valid stop always leaves the timer paused.
   assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_STOP && unit_ok |=> !running_ff)
      else $error("stop did not pause the timer");

   // A valid init clears the counter and starts the timer.
   assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_INIT && unit_ok |=> count_ff == '0 && running_ff)
      else $error("init did not clear and start the timer");

   // An empty output register never blocks the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty output register");

   // Only a tick word reports fired channels.
   assert property (@(posedge clock) disable iff (reset)
      accept && action != ACT_TICK |=> rsp_data_ff[MASK_W-1:0] == '0)
      else $error("fired mask on a non-tick word");

endmodule

>>> rtl/fatm_alarm_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm bank
// Holds the alarm time, armed flag and period of every channel, compares
// them against the counter on a tick and re-arms or disarms fired channels.
// ----------------------------------------------------------------------------
module fatm_alarm_bank
   import fatm_pkg::*;
#(
   parameter int unsigned CHANNELS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  bank_cmd_type        cmd,
   output logic [CHANNELS-1:0] fired
);

   logic [VALUE_W-1:0]  alarm_ff  [CHANNELS];
   logic [VALUE_W-1:0]  alarm_in  [CHANNELS];
   logic [VALUE_W-1:0]  period_ff [CHANNELS];
   logic [VALUE_W-1:0]  period_in [CHANNELS];
   logic [CHANNELS-1:0] armed_ff;
   logic [CHANNELS-1:0] armed_in;
   logic [VALUE_W-1:0]  rearm_base;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         fired[c] = cmd.tick && armed_ff[c] && (alarm_ff[c] == cmd.now);
      end
      rearm_base = ((|fired) && cmd.reset_on_match) ? '0 : cmd.now;

      for (int c = 0; c < CHANNELS; c++) begin
         alarm_in[c]  = alarm_ff[c];
         period_in[c] = period_ff[c];
         armed_in[c]  = armed_ff[c];
         if (fired[c]) begin
            if (period_ff[c] != '0) begin
               alarm_in[c] = rearm_base + period_ff[c];
               armed_in[c] = 1'b1;
            end else begin
               armed_in[c] = 1'b0;
            end
         end
         if (cmd.init) begin
            alarm_in[c] = '0;
            armed_in[c] = 1'b0;
         end
         if (cmd.set && (cmd.channel == CHAN_W'(c))) begin
            alarm_in[c]  = cmd.set_time;
            period_in[c] = cmd.set_period;
            armed_in[c]  = 1'b1;
         end
         if (cmd.clear && (cmd.channel == CHAN_W'(c))) begin
            period_in[c] = '0;
            armed_in[c]  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            alarm_ff[c]  <= '0;
            period_ff[c] <= '0;
         end
      end else begin
         armed_ff <= armed_in;
         for (int c = 0; c < CHANNELS; c++) begin
            alarm_ff[c]  <= alarm_in[c];
            period_ff[c] <= period_in[c];
         end
      end
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm timer core testbench
// Sends action words to the timer over the request stream and checks every
// response word against the directed table or a cycle-free predictor of the
// counter and the alarm channels. A short table of directed words covers reset
// values, index errors, unused action codes and the field extremes. Phases
// of random words follow, mostly ticks and well-formed set, clear and read
// actions, under every setting of the two control registers. Both stream sides
// idle at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
   import fatm_pkg::*;

   localparam int unsigned CHANNELS      = 4;
   localparam int unsigned UNITS         = 1;
   localparam int unsigned PHASE_WORDS   = 110;
   localparam int unsigned RANDOM_PHASES = 5;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned LONG_HOLD     = 60;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic [MASK_W-1:0]  mask;
      logic [VALUE_W-1:0] rd;
      logic               status;
   } timer_rsp_type;

   typedef struct {
      logic [ACTION_W-1:0] act;
      logic [UNIT_W-1:0]   unit;
      logic [CHAN_W-1:0]   chan;
      logic [VALUE_W-1:0]  val;
      bit                  typed;
      logic [MASK_W-1:0]   w_mask;
      logic [VALUE_W-1:0]  w_read;
      logic                w_status;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_index;
   logic                  csr_wdata;

   // Predicted timer state.
   logic [63:0]        tick_cnt;
   bit                 timer_running;
   logic [VALUE_W-1:0] alarm_at [CHANNELS];
   bit                 alarm_on [CHANNELS];
   logic [VALUE_W-1:0] alarm_period [CHANNELS];
   bit                 clr_on_match;
   bit                 clr_on_set;

   timer_rsp_type pending_rsp_q[$];
   stim_row_type  directed_rows[25];

   int unsigned mismatches;
   int unsigned words_checked;
   int unsigned fired_words;
   int unsigned index_errors;
   int unsigned cycles;
   bit          quiet_phase;
   bit          hold_rsp;

   four_channel_alarm_timer_core #(
      .CHANNELS(CHANNELS),
      .UNITS   (UNITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding.",
                  cycles, pending_rsp_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic timer_rsp_type advance_timer(input logic [ACTION_W-1:0] act,
                                                   input logic [UNIT_W-1:0]   unit,
                                                   input logic [CHAN_W-1:0]   chan,
                                                   input logic [VALUE_W-1:0]  val);
      timer_rsp_type      r;
      bit                 unit_ok;
      bit                 chan_ok;
      bit                 needs_chan;
      logic [VALUE_W-1:0] now;
      r          = '0;
      unit_ok    = unit < UNITS;
      chan_ok    = chan < CHANNELS;
      needs_chan = act >= ACT_SET_REL && act <= ACT_CLEAR;
      if (act == ACT_TICK) begin
         if (timer_running) begin
            tick_cnt = tick_cnt + 64'd1;
            now = tick_cnt[31:0];
            for (int c = 0; c < CHANNELS; c++) begin
               if (alarm_on[c] && alarm_at[c] == now) begin
                  r.mask[c] = 1'b1;
               end
            end
            if (r.mask != '0 && clr_on_match) begin
               tick_cnt = '0;
            end
            now = tick_cnt[31:0];
            for (int c = 0; c < CHANNELS; c++) begin
               if (r.mask[c]) begin
                  if (alarm_period[c] != '0) begin
                     alarm_at[c] = now + alarm_period[c];
                     alarm_on[c] = 1'b1;
                  end else begin
                     alarm_on[c] = 1'b0;
                  end
               end
            end
         end
      end else if (act >= ACT_INIT && act <= ACT_STOP) begin
         if (!unit_ok || (needs_chan && !chan_ok)) begin
            r.status = 1'b1;
         end else begin
            case (act)
               ACT_INIT: begin
                  tick_cnt = '0;
                  for (int c = 0; c < CHANNELS; c++) begin
                     alarm_at[c] = '0;
                     alarm_on[c] = 1'b0;
                  end
                  timer_running = 1'b1;
               end
               ACT_SET_REL: begin
                  alarm_period[chan] = '0;
                  alarm_at[chan]     = tick_cnt[31:0] + val;
                  alarm_on[chan]     = 1'b1;
               end
               ACT_SET_ABS: begin
                  alarm_period[chan] = '0;
                  tick_cnt           = '0;
                  alarm_at[chan]     = val;
                  alarm_on[chan]     = 1'b1;
                  timer_running      = 1'b1;
               end
               ACT_SET_PER: begin
                  if (clr_on_set) begin
                     tick_cnt = '0;
                  end
                  alarm_period[chan] = val;
                  alarm_at[chan]     = tick_cnt[31:0] + val;
                  alarm_on[chan]     = 1'b1;
                  timer_running      = 1'b1;
               end
               ACT_CLEAR: begin
                  alarm_on[chan]     = 1'b0;
                  alarm_period[chan] = '0;
               end
               ACT_READ: begin
                  r.rd = tick_cnt[31:0];
               end
               ACT_START: begin
                  timer_running = 1'b1;
               end
               default: begin
                  timer_running = 1'b0;
               end
            endcase
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 40) begin
         $display("Mismatch on %s at cycle %0d: got %h, expected %h",
                  what, cycles, got, want);
      end
      mismatches++;
   endtask

   // Response checker; a word seen here is taken at the next rising edge.
   always @(negedge clock) begin
      timer_rsp_type got;
      timer_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mask   = rsp_tdata[3:0];
         got.rd     = rsp_tdata[35:4];
         got.status = rsp_tdata[36];
         words_checked++;
         if (got.mask != '0) begin
            fired_words++;
         end
         if (got.status) begin
            index_errors++;
         end
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response word", rsp_tdata[31:0], '0);
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.mask !== want.mask) begin
               report_mismatch("fired_mask", 32'(got.mask), 32'(want.mask));
            end
            if (got.rd !== want.rd) begin
               report_mismatch("read_value", got.rd, want.rd);
            end
            if (got.status !== want.status) begin
               report_mismatch("status", 32'(got.status), 32'(want.status));
            end
         end
      end
   end

   // Response side ready, with random stalls and one long hold-off.
   initial begin
      int unsigned g;
      bit          held_once;
      rsp_tready = 1'b0;
      held_once  = 1'b0;
      forever begin
         if (hold_rsp && !held_once) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held_once = 1'b1;
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_tready <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [UNIT_W-1:0]   unit,
                            input logic [CHAN_W-1:0]   chan,
                            input logic [VALUE_W-1:0]  val,
                            input bit                  typed,
                            input timer_rsp_type       want);
      int unsigned   g;
      bit            taken;
      timer_rsp_type predicted;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, val, chan, unit, act};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         if (taken) begin
            predicted = advance_timer(act, unit, chan, val);
            pending_rsp_q.push_back(typed ? want : predicted);
         end
         @(posedge clock);
      end
   endtask

   task automatic drain_words();
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic set_controls(input bit on_match, input bit on_set);
      csr_we    <= 1'b1;
      csr_index <= CSR_RESET_ON_MATCH;
      csr_wdata <= on_match;
      @(posedge clock);
      csr_index <= CSR_RESET_ON_SET;
      csr_wdata <= on_set;
      @(posedge clock);
      csr_we <= 1'b0;
      clr_on_match = on_match;
      clr_on_set   = on_set;
   endtask

   task automatic send_random_word();
      int unsigned         r;
      logic [ACTION_W-1:0] act;
      logic [UNIT_W-1:0]   unit;
      logic [CHAN_W-1:0]   chan;
      logic [VALUE_W-1:0]  val;
      r    = $urandom_range(0, 99);
      unit = '0;
      chan = CHAN_W'($urandom_range(0, CHANNELS - 1));
      val  = $urandom_range(0, 6);
      if (r < 52) begin
         act  = ACT_TICK;
         unit = UNIT_W'($urandom);
         chan = CHAN_W'($urandom);
         val  = $urandom;
      end else if (r < 62) begin
         act = ACT_SET_REL;
      end else if (r < 70) begin
         act = ACT_SET_PER;
      end else if (r < 74) begin
         act = ACT_SET_ABS;
         val = $urandom_range(0, 12);
      end else if (r < 78) begin
         act = ACT_CLEAR;
      end else if (r < 83) begin
         act = ACT_READ;
      end else if (r < 85) begin
         act = ACT_START;
      end else if (r < 86) begin
         act = ACT_STOP;
      end else if (r < 87) begin
         act = ACT_INIT;
      end else begin
         act  = ACTION_W'($urandom);
         unit = UNIT_W'($urandom);
         chan = CHAN_W'($urandom);
         val  = $urandom;
      end
      send_word(act, unit, chan, val, 1'b0, '0);
   endtask

   initial begin
      bit            on_match;
      bit            on_set;
      timer_rsp_type want;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_RESET_ON_MATCH;
      csr_wdata  = 1'b0;
      mismatches = 0;
      words_checked = 0;
      fired_words   = 0;
      index_errors  = 0;
      quiet_phase   = 1'b0;
      hold_rsp      = 1'b0;
      tick_cnt      = '0;
      timer_running = 1'b0;
      clr_on_match  = 1'b0;
      clr_on_set    = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         alarm_at[c]     = '0;
         alarm_on[c]     = 1'b0;
         alarm_period[c] = '0;
      end

      directed_rows = '{
         '{ACT_READ,      2'd0, 3'd0, 32'h0,        1'b1, 4'h0, 32'h0, 1'b0},
         '{ACT_TICK,      2'd3, 3'd7, 32'hFFFFFFFF, 1'b1, 4'h0, 32'h0, 1'b0},
         '{ACT_READ,      2'd3, 3'd0, 32'h0,        1'b1, 4'h0, 32'h0, 1'b1},
         '{ACT_SET_REL,   2'd0, 3'd7, 32'h5,        1'b1, 4'h0, 32'h0, 1'b1},
         '{ACT_INIT,      2'd2, 3'd0, 32'h0,        1'b1, 4'h0, 32'h0, 1'b1},
         '{ACT_CLEAR,     2'd0, 3'd4, 32'h0,        1'b1, 4'h0, 32'h0, 1'b1},
         '{ACT_START,     2'd1, 3'd0, 32'h0,        1'b1, 4'h0, 32'h0, 1'b1},
         '{ACT_UNUSED_HI, 2'd3, 3'd7, 32'hFFFFFFFF, 1'b1, 4'h0, 32'h0, 1'b0},
         '{ACT_UNUSED_LO, 2'd0, 3'd0, 32'h0,        1'b1, 4'h0, 32'h0, 1'b0},
         '{ACT_INIT,      2'd0, 3'd5, 32'h0,        1'b1, 4'h0, 32'h0, 1'b0},
         '{ACT_SET_REL,   2'd0, 3'd0, 32'h2,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_TICK,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_TICK,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_SET_PER,   2'd0, 3'd1, 32'h3,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_SET_ABS,   2'd0, 3'd2, 32'hFFFFFFFF, 1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_SET_ABS,   2'd0, 3'd3, 32'h1,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_TICK,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_CLEAR,     2'd0, 3'd1, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_TICK,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_TICK,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_STOP,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_TICK,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_READ,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_START,     2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0},
         '{ACT_READ,      2'd0, 3'd0, 32'h0,        1'b0, 4'h0, 32'h0, 1'b0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         want.mask   = directed_rows[i].w_mask;
         want.rd     = directed_rows[i].w_read;
         want.status = directed_rows[i].w_status;
         send_word(directed_rows[i].act, directed_rows[i].unit, directed_rows[i].chan,
                   directed_rows[i].val, directed_rows[i].typed, want);
      end
      drain_words();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin on_match = 1'b1; on_set = 1'b0; end
            1: begin on_match = 1'b0; on_set = 1'b1; end
            2: begin on_match = 1'b1; on_set = 1'b1; end
            3: begin on_match = 1'b0; on_set = 1'b0; end
            default: begin
               on_match = 1'($urandom_range(0, 1));
               on_set   = 1'($urandom_range(0, 1));
            end
         endcase
         set_controls(on_match, on_set);
         quiet_phase = (p == 3);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 1 && n == 30) begin
               hold_rsp = 1'b1;
            end
            send_random_word();
         end
         drain_words();
      end

      $display("Checked %0d response words over %0d control settings.",
               words_checked, RANDOM_PHASES + 1);
      $display("Alarms fired in %0d words; %0d words reported an index error.",
               fired_words, index_errors);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches found.", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
